// ===== design/hdc_pkg.sv =====
package hdc_pkg;
	localparam int Capacity = 1024;
	localparam int KeyBits = 64;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = IdxW + 1;
	localparam int QDepth = 2;

	// request handed from front to back
	typedef struct packed {
		logic [KeyBits-1:0] key;
		logic               full;
	} hdc_req_t;

	// one result
	typedef struct packed {
		logic            full_error;
		logic [IdxW-1:0] position;
		logic            is_first;
		logic [IdxW-1:0] compact_index;
		logic [IdxW-1:0] first_position;
		logic [CntW-1:0] unique_total;
	} hdc_res_t;

	localparam logic [0:0] RegCapacity = 1'b0;
endpackage

// ===== design/hdc_ram.sv =====
module hdc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/hdc_front.sv =====
module hdc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    ready,
	input  logic [63:0]             key,
	input  logic [hdc_pkg::CntW-1:0] limit,
	output logic                    q_valid,
	input  logic                    q_ready,
	output hdc_pkg::hdc_req_t       q_data
);
	import hdc_pkg::*;

	logic [CntW-1:0] eff_limit;
	logic [CntW-1:0] pos_q;
	logic [$clog2(QDepth+1)-1:0] cnt_q;
	logic [$clog2(QDepth)-1:0] wp_q, rp_q;
	hdc_req_t buf_q [QDepth];
	logic push, pop;

	// positions are known at accept, so full is decided here
	assign eff_limit = (limit > CntW'(Capacity)) ? CntW'(Capacity) : limit;
	assign ready = (cnt_q != ($clog2(QDepth+1))'(QDepth));
	assign push = valid && ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != '0);
	assign q_data = buf_q[rp_q];

	// request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			pos_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
				if (pos_q < eff_limit) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + ($clog2(QDepth+1))'(push) - ($clog2(QDepth+1))'(pop);
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q].key <= key[KeyBits-1:0];
			buf_q[wp_q].full <= !(pos_q < eff_limit);
		end
	end
endmodule

// ===== design/hdc_back.sv =====
module hdc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  hdc_pkg::hdc_req_t q_data,
	output logic              res_valid,
	input  logic              res_ready,
	output hdc_pkg::hdc_res_t res
);
	import hdc_pkg::*;

	typedef enum logic [1:0] {IDLE, READ, CMP, DONE} state_t;

	state_t state_q;
	logic [KeyBits-1:0] key_q;
	logic [CntW-1:0] pos_q, uniq_q, idx_q;
	logic found_q;
	logic [IdxW-1:0] fpos_q;
	logic [KeyBits+IdxW-1:0] rdata;
	logic we;
	logic [IdxW-1:0] raddr;

	assign q_ready = (state_q == IDLE) && !res_valid;
	assign we = (state_q == DONE) && !found_q && (uniq_q < CntW'(Capacity));
	assign raddr = idx_q[IdxW-1:0];

	hdc_ram #(.Width(KeyBits + IdxW), .Depth(Capacity)) u_ram (
		.clk(clk), .we(we), .waddr(uniq_q[IdxW-1:0]),
		.wdata({key_q, pos_q[IdxW-1:0]}), .raddr(raddr), .rdata(rdata)
	);

	// scan stored keys, one ram read and compare per key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			res_valid <= 1'b0;
			pos_q <= '0;
			uniq_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (q_valid && q_ready) begin
						key_q <= q_data.key;
						idx_q <= '0;
						found_q <= 1'b0;
						if (q_data.full) begin
							res <= '{full_error: 1'b1, default: '0};
							res_valid <= 1'b1;
						end else if (uniq_q == '0) begin
							state_q <= DONE;
						end else begin
							state_q <= READ;
						end
					end
				end
				READ: begin
					state_q <= CMP;
				end
				CMP: begin
					if (rdata[KeyBits+IdxW-1:IdxW] == key_q) begin
						found_q <= 1'b1;
						fpos_q <= rdata[IdxW-1:0];
						state_q <= DONE;
					end else if (idx_q + 1'b1 == uniq_q) begin
						state_q <= DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= READ;
					end
				end
				DONE: begin
					res.full_error <= 1'b0;
					res.position <= pos_q[IdxW-1:0];
					res.is_first <= !found_q;
					res.compact_index <= uniq_q[IdxW-1:0];
					res.first_position <= found_q ? fpos_q : pos_q[IdxW-1:0];
					res.unique_total <= we ? uniq_q + 1'b1 : uniq_q;
					if (we) begin
						uniq_q <= uniq_q + 1'b1;
					end
					pos_q <= pos_q + 1'b1;
					res_valid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== design/hash_dedup_compactor_unit.sv =====
// channel  | handshake           | payload
// in       | valid / ready       | key
// out      | out_valid/out_ready | full_error position is_first compact_index
//          |                     | first_position unique_total
// cfg      | apb psel/penable    | capacity_limit at 0x0
// an item is scanned against up to u unique keys stored (one ram read per key);
// refused items skip the scan. reset clears counts only, the key ram is never
// swept. a two-entry request queue lets input keep flowing while the
// back end scans; results are held until out_ready.
module hash_dedup_compactor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        full_error,
	output logic [9:0]  position,
	output logic        is_first,
	output logic [9:0]  compact_index,
	output logic [9:0]  first_position,
	output logic [10:0] unique_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hdc_pkg::*;

	logic [CntW-1:0] limit_q;
	logic q_valid, q_ready;
	hdc_req_t q_data;
	hdc_res_t res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegCapacity) ? 32'(limit_q) : '0;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CntW'(Capacity);
		end else if (psel && penable && pwrite && paddr[2] == RegCapacity) begin
			limit_q <= pwdata[CntW-1:0];
		end
	end

	hdc_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready), .key(key),
		.limit(limit_q), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	hdc_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .res_valid(out_valid), .res_ready(out_ready), .res(res)
	);

	assign full_error = res.full_error;
	assign position = res.position;
	assign is_first = res.is_first;
	assign compact_index = res.compact_index;
	assign first_position = res.first_position;
	assign unique_total = res.unique_total;
endmodule
